// File: src/tppk_pkg.sv
// Package for the triangle pair index packer: widths, the job record that
// passes from the front to the back, and helpers for vertex rotation.
// No dependencies.
`default_nettype none

package tppk_pkg;

   // Vertex index width, 8 to 31
   localparam int IndexBits  = 31;
   localparam int TriVerts   = 3;
   localparam int MaxOut     = 6;
   localparam int QueueDepth = 2;

   localparam int CountBits = $clog2(MaxOut + 1);
   localparam int PosBits   = $clog2(MaxOut);
   localparam int PtrBits   = $clog2(QueueDepth);
   localparam int FillBits  = $clog2(QueueDepth + 1);

   // Result counts of the possible jobs
   localparam logic [CountBits-1:0] CountNone   = CountBits'(0);
   localparam logic [CountBits-1:0] CountTri    = CountBits'(3);
   localparam logic [CountBits-1:0] CountMerge  = CountBits'(4);
   localparam logic [CountBits-1:0] CountTwoTri = CountBits'(6);

   typedef logic [IndexBits-1:0] index_type;
   typedef index_type [TriVerts-1:0] tri_type;

   // One item's worth of results, in emit order starting at idx[0]
   typedef struct packed {
      index_type [MaxOut-1:0] idx;
      logic [CountBits-1:0]   cnt;
      logic                   fin;
   } job_type;

   // Queue status seen by the back end
   typedef struct packed {
      logic    head_valid;
      job_type head;
   } queue_head_type;

   // Next vertex position around a triangle
   function automatic int tri_next(input int k);
      return (k == TriVerts - 1) ? 0 : k + 1;
   endfunction

   // Rotate so that the first index is at least the second
   function automatic tri_type tri_rotate(input tri_type t);
      tri_type r;
      if (t[0] >= t[1]) begin
         r[0] = t[0];
         r[1] = t[1];
         r[2] = t[2];
      end else if (t[1] >= t[2]) begin
         r[0] = t[1];
         r[1] = t[2];
         r[2] = t[0];
      end else begin
         r[0] = t[2];
         r[1] = t[0];
         r[2] = t[1];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/tppk_if.sv
// Channel interfaces for the triangle pair index packer: request (one
// triangle) and response (one packed index). Depends on tppk_pkg.
`default_nettype none

interface tppk_req_if import tppk_pkg::*; ();
   logic      valid;
   logic      ready;
   index_type vert_first;
   index_type vert_second;
   index_type vert_third;
   logic      final_triangle;

   modport source (output valid, vert_first, vert_second, vert_third, final_triangle,
                   input ready);
   modport sink   (input valid, vert_first, vert_second, vert_third, final_triangle,
                   output ready);
endinterface

interface tppk_rsp_if import tppk_pkg::*; ();
   logic      valid;
   logic      ready;
   index_type packed_index;
   logic      run_end;
   logic      stream_end;

   modport source (output valid, packed_index, run_end, stream_end, input ready);
   modport sink   (input valid, packed_index, run_end, stream_end, output ready);
endinterface

`default_nettype wire

// File: src/triangle_pair_index_packer_core.sv
// Triangle pair index packer, top level: front end, job queue, back end.
// The first index caused by a request is written into the job queue and then
// loaded into the response output register before it shows on the response.
// Throughput: one request a cycle while the job queue has room; the back end
// sends one index a cycle unless the response stalls; 0, 3, 4 or 6 per request.
// Reset (synchronous, active high) clears the pending flag, queue and output.
`default_nettype none

module triangle_pair_index_packer_core import tppk_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tppk_req_if.sink   req_chan,
   tppk_rsp_if.source rsp_chan
);

   logic           push_valid;
   job_type        push_job;
   logic           queue_full;
   logic           pop;
   queue_head_type head;

   tppk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   tppk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_out   (head)
   );

   tppk_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_in  (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: src/tppk_front.sv
// Front end: accepts triangles, holds the pending one, finds a shared edge
// and builds the job of indices to emit. Depends on tppk_pkg, tppk_if.
`default_nettype none

module tppk_front import tppk_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   tppk_req_if.sink     req_chan,
   input  wire logic    queue_full,
   output logic         push_valid,
   output job_type      push_job
);

   logic      pend_valid_ff, pend_valid_in;
   tri_type   pend_tri_ff;
   tri_type   new_tri;
   logic      accept;
   logic      degen;
   logic      found;
   logic      merge;
   index_type sel_a, sel_b, sel_c, sel_d;
   tri_type   rot_pend, rot_new;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign new_tri[0] = req_chan.vert_first;
   assign new_tri[1] = req_chan.vert_second;
   assign new_tri[2] = req_chan.vert_third;

   // Degenerate pending triangle never merges
   assign degen = (pend_tri_ff[0] == pend_tri_ff[1]) || (pend_tri_ff[1] == pend_tri_ff[2]) ||
                  (pend_tri_ff[2] == pend_tri_ff[0]);

   // Search pending edges in order for the reversed edge in the new triangle
   always_comb begin
      found = 1'b0;
      sel_a = pend_tri_ff[0];
      sel_b = pend_tri_ff[1];
      sel_c = pend_tri_ff[2];
      sel_d = new_tri[0];
      for (int i = 0; i < TriVerts; i++) begin
         for (int j = 0; j < TriVerts; j++) begin
            if (!found && new_tri[j] == pend_tri_ff[tri_next(i)] &&
                new_tri[tri_next(j)] == pend_tri_ff[i]) begin
               found = 1'b1;
               sel_a = pend_tri_ff[i];
               sel_b = pend_tri_ff[tri_next(i)];
               sel_c = pend_tri_ff[tri_next(tri_next(i))];
               sel_d = new_tri[tri_next(tri_next(j))];
            end
         end
      end
   end

   assign merge    = pend_valid_ff && !degen && found;
   assign rot_pend = tri_rotate(pend_tri_ff);
   assign rot_new  = tri_rotate(new_tri);

   // Build the job
   always_comb begin
      push_job     = '0;
      push_job.fin = req_chan.final_triangle;
      if (pend_valid_ff) begin
         if (merge) begin
            push_job.cnt = CountMerge;
            if (sel_a < sel_b) begin
               push_job.idx[0] = sel_a;
               push_job.idx[1] = sel_b;
               push_job.idx[2] = sel_c;
               push_job.idx[3] = sel_d;
            end else begin
               push_job.idx[0] = sel_b;
               push_job.idx[1] = sel_a;
               push_job.idx[2] = sel_d;
               push_job.idx[3] = sel_c;
            end
         end else begin
            push_job.idx[0] = rot_pend[0];
            push_job.idx[1] = rot_pend[1];
            push_job.idx[2] = rot_pend[2];
            push_job.idx[3] = rot_new[0];
            push_job.idx[4] = rot_new[1];
            push_job.idx[5] = rot_new[2];
            push_job.cnt    = req_chan.final_triangle ? CountTwoTri : CountTri;
         end
      end else begin
         push_job.idx[0] = rot_new[0];
         push_job.idx[1] = rot_new[1];
         push_job.idx[2] = rot_new[2];
         push_job.cnt    = req_chan.final_triangle ? CountTri : CountNone;
      end
   end

   assign push_valid = accept && (push_job.cnt != CountNone);

   // New triangle stays pending unless merged or flushed
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = !merge && !req_chan.final_triangle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Hold the pending triangle
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_tri_ff <= new_tri;
      end
   end

endmodule

`default_nettype wire

// File: src/tppk_queue.sv
// Job queue between front and back end, two entries deep.
// Depends on tppk_pkg.
`default_nettype none

module tppk_queue import tppk_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire job_type  push_job,
   output logic          full,
   input  wire logic     pop,
   output queue_head_type head_out
);

   job_type             job_ff [QueueDepth];
   logic [PtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillBits-1:0] fill_ff, fill_in;

   assign full                = (fill_ff == FillBits'(QueueDepth));
   assign head_out.head_valid = (fill_ff != '0);
   assign head_out.head       = job_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push_valid && !pop) begin
         fill_in = fill_ff + FillBits'(1);
      end else if (pop && !push_valid) begin
         fill_in = fill_ff - FillBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push_valid) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("job pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_out.head_valid)
      else $error("job popped from empty queue");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillBits'(QueueDepth))
      else $error("queue fill count out of range");

   a_head_nonempty_job: assert property (@(posedge clock) disable iff (reset)
      head_out.head_valid |-> head_out.head.cnt != CountNone)
      else $error("empty job stored in queue");
`endif

endmodule

`default_nettype wire

// File: src/tppk_back.sv
// Back end: walks the head job one index per cycle, while the response is not
// stalled, into the response output register. Depends on tppk_pkg, tppk_if.
`default_nettype none

module tppk_back import tppk_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_head_type head_in,
   output logic                pop,
   tppk_rsp_if.source          rsp_chan
);

   logic                 rsp_valid_ff, rsp_valid_in;
   index_type            index_ff;
   logic                 run_end_ff;
   logic                 stream_end_ff;
   logic [PosBits-1:0]   pos_ff, pos_in;
   logic                 load;
   logic                 last;

   assign load = head_in.head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign last = (CountBits'(pos_ff) == head_in.head.cnt - CountBits'(1));
   assign pop  = load && last;

   // Advance through the job, drop it after its last index
   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         pos_in       = last ? '0 : pos_ff + PosBits'(1);
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         index_ff      <= head_in.head.idx[pos_ff];
         run_end_ff    <= last;
         stream_end_ff <= last && head_in.head.fin;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.packed_index = index_ff;
   assign rsp_chan.run_end      = run_end_ff;
   assign rsp_chan.stream_end   = stream_end_ff;

endmodule

`default_nettype wire
